FILE: sv/stepper_current_profile_policy_defines.svh
// Assertion macros for the stepper current profile policy checker.
// Expects clk and arst_n to be visible where the macros are used.
`ifndef STEPPER_CURRENT_PROFILE_POLICY_DEFINES_SVH
`define STEPPER_CURRENT_PROFILE_POLICY_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SCPP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("scpp check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define SCPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scpp check failed");

`endif

FILE: sv/scpp_pkg.sv
// Shared types and constants of the stepper current profile policy.
// No dependencies; imported by every module of the block.
package scpp_pkg;

	localparam int SPEED_WIDTH = 20;
	localparam int COORD_WIDTH = 24;
	localparam int MA_WIDTH    = 11;
	localparam int REG_IDX_W   = 3;

	localparam int MA_MAX        = 1500;
	localparam int MA_HOLD       = 450;
	localparam int MA_CRUISE_DEF = 850;
	localparam int MA_FAST_DEF   = 1050;
	localparam int PCT_IDLE      = 15;
	localparam int PCT_MOVE      = 35;

	localparam int SPD_HOLD_UP     = 700;
	localparam int SPD_CRUISE_DOWN = 250;
	localparam int SPD_FAST_UP     = 5200;
	localparam int SPD_FAST_DOWN   = 4200;
	localparam int SPD_SAFE        = 150;

	localparam int STEP_DWELL_MS    = 220;
	localparam int PROFILE_DWELL_MS = 120;
	localparam int SHORT_STEPS      = 160;

	localparam logic [REG_IDX_W-1:0] REG_DRIVERS_READY = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_CRUISE_OVR    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FAST_OVR      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DIAG_GRP      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LINE_GRP      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SHORT_GRP     = 3'd5;

	localparam logic OP_SERVICE = 1'b0;
	localparam logic OP_MOVE    = 1'b1;

	typedef enum logic [1:0] {
		PROF_HOLD   = 2'd0,
		PROF_CRUISE = 2'd1,
		PROF_FAST   = 2'd2
	} prof_t;

	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_SHORT = 2'd1,
		CLS_DIAG  = 2'd2,
		CLS_LINE  = 2'd3
	} cls_t;

	typedef struct packed {
		logic                          operation;
		logic [31:0]                   now_ms;
		logic signed [SPEED_WIDTH-1:0] speed_a;
		logic signed [SPEED_WIDTH-1:0] speed_b;
		logic                          wants_move;
		logic                          precision_mode;
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
	} in_t;

	typedef struct packed {
		logic [1:0]          profile_now;
		logic [MA_WIDTH-1:0] run_current_ma;
		logic [5:0]          hold_percent;
		logic                fine_steps;
		logic                profile_applied;
		logic                steps_switched;
		logic [1:0]          move_class;
	} out_t;

endpackage

FILE: sv/scpp_move_class.sv
// Planned move classifier: short, diagonal or line from start and end points.
// Depends on scpp_pkg for the coordinate width and class codes.
module scpp_move_class (
	input  scpp_pkg::in_t  item,
	output scpp_pkg::cls_t cls
);
	import scpp_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = COORD_WIDTH + 5;

	logic signed [DW-1:0] dx_s, dy_s;
	logic [DW-1:0]        dx, dy, hi, lo;
	logic [PW-1:0]        hi_ext, lo_ext, lo10, hi3;

	always_comb begin
		dx_s = $signed({item.end_x[COORD_WIDTH-1], item.end_x})
			- $signed({item.start_x[COORD_WIDTH-1], item.start_x});
		dy_s = $signed({item.end_y[COORD_WIDTH-1], item.end_y})
			- $signed({item.start_y[COORD_WIDTH-1], item.start_y});
		dx = dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
		dy = dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
		hi = (dx > dy) ? dx : dy;
		lo = (dx < dy) ? dx : dy;
		hi_ext = PW'(hi);
		lo_ext = PW'(lo);
		// Diagonal when the short side is at least 0.3 of the long side.
		lo10 = (lo_ext << 3) + (lo_ext << 1);
		hi3  = (hi_ext << 1) + hi_ext;
		if (hi <= DW'(SHORT_STEPS)) begin
			cls = CLS_SHORT;
		end else if (lo != '0 && lo10 >= hi3) begin
			cls = CLS_DIAG;
		end else begin
			cls = CLS_LINE;
		end
	end

endmodule

FILE: sv/stepper_current_profile_policy.sv
// Top level of the stepper current profile policy.
// Depends on scpp_pkg and instantiates scpp_move_class.
//
// Usage: input beats arrive on in_valid/in_stall with an in_data payload.
// A service beat (operation 0) updates the microstep mode and the
// hold/cruise/fast profile from the axis speeds and flags while the drivers
// are ready; a move beat (operation 1), while some group current is set,
// classifies a planned move and may load a new cruise current. Every input
// beat yields exactly one result beat on out_valid/out_stall. The result of the
// beat in the input stage is registered once the output register is free or
// drains. Throughput is one beat per cycle while the receiver does not
// stall; the state update and the result come from one short pass of logic
// between the two registers. When the receiver stalls, the result holds in
// the output register and the input stage can still take one more beat; a
// further beat then sees in_stall until the output drains. Configuration is
// written through wr_en/wr_index/wr_data while the block is idle; current
// registers saturate to 1500 mA on write. Reset clears both stages, selects
// the cruise profile with fine steps, and zeroes timestamps and currents.
module stepper_current_profile_policy (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  scpp_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output scpp_pkg::out_t                     out_data,
	input  logic                               wr_en,
	input  logic [scpp_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [scpp_pkg::MA_WIDTH-1:0]      wr_data
);
	import scpp_pkg::*;

	// Input stage and output register.
	logic           valid_s1;
	in_t            data_s1;
	logic           out_valid_q;
	out_t           out_q;
	logic           advance;

	// Configuration registers.
	logic                drivers_ready_q;
	logic [MA_WIDTH-1:0] fast_ovr_q, diag_grp_q, line_grp_q, short_grp_q;

	// Policy state.
	prof_t               profile_q;
	logic                fine_q;
	logic [31:0]         last_step_q, last_prof_q;
	logic [MA_WIDTH-1:0] active_cruise_q;

	// Next state and result of the beat in the input stage.
	prof_t               profile_n, want_prof;
	logic                fine_n;
	logic [31:0]         last_step_n, last_prof_n;
	logic [MA_WIDTH-1:0] active_n, grp_ma, wr_sat;
	logic                applied, switched, want_fine;
	cls_t                cls_raw, cls_out;
	logic [SPEED_WIDTH-1:0] va, vb, vmax;
	out_t                result;

	scpp_move_class u_cls (
		.item (data_s1),
		.cls  (cls_raw)
	);

	// The input stage moves on whenever the output register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign wr_sat = (wr_data > MA_WIDTH'(MA_MAX)) ? MA_WIDTH'(MA_MAX) : wr_data;

	always_comb begin
		profile_n   = profile_q;
		fine_n      = fine_q;
		last_step_n = last_step_q;
		last_prof_n = last_prof_q;
		active_n    = active_cruise_q;
		applied     = 1'b0;
		switched    = 1'b0;
		cls_out     = CLS_NONE;
		want_prof   = profile_q;
		grp_ma      = active_cruise_q;

		va   = data_s1.speed_a[SPEED_WIDTH-1] ? SPEED_WIDTH'(-data_s1.speed_a)
			: SPEED_WIDTH'(data_s1.speed_a);
		vb   = data_s1.speed_b[SPEED_WIDTH-1] ? SPEED_WIDTH'(-data_s1.speed_b)
			: SPEED_WIDTH'(data_s1.speed_b);
		vmax = (va > vb) ? va : vb;
		want_fine = data_s1.precision_mode || !data_s1.wants_move;

		if (data_s1.operation == OP_SERVICE) begin
			if (drivers_ready_q) begin
				// Microstep changes only near standstill or at idle, after the dwell.
				if (want_fine != fine_q
					&& (data_s1.now_ms - last_step_q) >= 32'(STEP_DWELL_MS)
					&& (!data_s1.wants_move || vmax <= SPEED_WIDTH'(SPD_SAFE))) begin
					fine_n      = want_fine;
					last_step_n = data_s1.now_ms;
					switched    = 1'b1;
				end

				// Profile follows speed with hysteresis between the thresholds.
				if (!data_s1.wants_move) begin
					want_prof = PROF_HOLD;
				end else begin
					unique case (profile_q)
						PROF_FAST: begin
							if (vmax <= SPEED_WIDTH'(SPD_FAST_DOWN)) want_prof = PROF_CRUISE;
						end
						PROF_CRUISE: begin
							if (vmax >= SPEED_WIDTH'(SPD_FAST_UP)) begin
								want_prof = PROF_FAST;
							end else if (vmax <= SPEED_WIDTH'(SPD_CRUISE_DOWN)
								&& !data_s1.precision_mode) begin
								want_prof = PROF_HOLD;
							end
						end
						default: begin
							if (vmax >= SPEED_WIDTH'(SPD_HOLD_UP) || data_s1.precision_mode)
								want_prof = PROF_CRUISE;
						end
					endcase
				end

				if (want_prof != profile_q
					&& (data_s1.now_ms - last_prof_q) >= 32'(PROFILE_DWELL_MS)) begin
					profile_n   = want_prof;
					last_prof_n = data_s1.now_ms;
					applied     = 1'b1;
				end
			end
		end else if (diag_grp_q != '0 || line_grp_q != '0 || short_grp_q != '0) begin
			cls_out = cls_raw;
			unique case (cls_raw)
				CLS_SHORT: grp_ma = short_grp_q;
				CLS_DIAG:  grp_ma = diag_grp_q;
				default:   grp_ma = line_grp_q;
			endcase
			// An unset group falls back to the active cruise current.
			if (grp_ma == '0) grp_ma = active_cruise_q;
			if (grp_ma != active_cruise_q) begin
				active_n = grp_ma;
				if (profile_q == PROF_CRUISE) begin
					last_prof_n = data_s1.now_ms;
					applied     = 1'b1;
				end
			end
		end

		result.profile_now = profile_n;
		unique case (profile_n)
			PROF_HOLD: result.run_current_ma = MA_WIDTH'(MA_HOLD);
			PROF_FAST: result.run_current_ma = (fast_ovr_q != '0) ? fast_ovr_q
				: MA_WIDTH'(MA_FAST_DEF);
			default:   result.run_current_ma = (active_n != '0) ? active_n
				: MA_WIDTH'(MA_CRUISE_DEF);
		endcase
		result.hold_percent    = (profile_n == PROF_HOLD) ? 6'(PCT_IDLE) : 6'(PCT_MOVE);
		result.fine_steps      = fine_n;
		result.profile_applied = applied;
		result.steps_switched  = switched;
		result.move_class      = cls_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	// Policy state and configuration registers. The user must write only while
	// idle, so a write and a beat never update the same register together;
	// the block does not enforce this. The cruise override is never read
	// back, so a write to it only loads the active cruise current.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drivers_ready_q <= 1'b1;
			fast_ovr_q      <= '0;
			diag_grp_q      <= '0;
			line_grp_q      <= '0;
			short_grp_q     <= '0;
			profile_q       <= PROF_CRUISE;
			fine_q          <= 1'b1;
			last_step_q     <= '0;
			last_prof_q     <= '0;
			active_cruise_q <= '0;
		end else begin
			if (advance) begin
				profile_q       <= profile_n;
				fine_q          <= fine_n;
				last_step_q     <= last_step_n;
				last_prof_q     <= last_prof_n;
				active_cruise_q <= active_n;
			end
			if (wr_en) begin
				unique case (wr_index)
					REG_DRIVERS_READY: drivers_ready_q <= wr_data[0];
					REG_CRUISE_OVR: active_cruise_q <= wr_sat;
					REG_FAST_OVR:  fast_ovr_q  <= wr_sat;
					REG_DIAG_GRP:  diag_grp_q  <= wr_sat;
					REG_LINE_GRP:  line_grp_q  <= wr_sat;
					REG_SHORT_GRP: short_grp_q <= wr_sat;
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: sv/scpp_checker.sv
// Port-level checks of the stepper current profile policy, bound to the top.
// Depends on scpp_pkg and the assertion macros header.
`include "stepper_current_profile_policy_defines.svh"

module scpp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_stall,
	input scpp_pkg::out_t out_data
);
	import scpp_pkg::*;

	logic       hold_beat;
	logic       move_beat;
	logic [5:0] pct_exp;

	assign hold_beat = out_valid && (out_data.profile_now == PROF_HOLD);
	assign move_beat = out_valid && (out_data.move_class != CLS_NONE);
	assign pct_exp   = (out_data.profile_now == PROF_HOLD) ? 6'(PCT_IDLE) : 6'(PCT_MOVE);

	// A stalled result beat stays offered and unchanged.
	`SCPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
	// The hold percent follows the reported profile.
	`SCPP_ASSERT(a_hold_pct, !out_valid || out_data.hold_percent == pct_exp)
	// The hold profile always drives the fixed hold current.
	`SCPP_ASSERT(a_hold_ma, !hold_beat || out_data.run_current_ma == MA_WIDTH'(MA_HOLD))
	// A classified move never switches microsteps.
	`SCPP_ASSERT(a_move_no_switch, !move_beat || !out_data.steps_switched)

endmodule

bind stepper_current_profile_policy scpp_checker u_scpp_checker (.*);

FILE: verif/testbench.sv
// Self-checking testbench for the stepper current profile policy block.
// Depends on scpp_pkg and the block's RTL; every result is predicted in place
// from the accepted input beats and the register settings.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import scpp_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_LIMIT     = 5000;
	localparam int RANDOM_PHASES   = 9;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int MAX_REPORTS     = 10;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_t                 out_data;
	logic                 wr_en     = 1'b0;
	logic [REG_IDX_W-1:0] wr_index  = '0;
	logic [MA_WIDTH-1:0]  wr_data   = '0;

	// Register copies held by the predictor. They change only when the
	// testbench writes a register, which it does while the block is idle.
	bit                  cfg_ready;
	logic [MA_WIDTH-1:0] cfg_fast;
	logic [MA_WIDTH-1:0] grp_diag;
	logic [MA_WIDTH-1:0] grp_line;
	logic [MA_WIDTH-1:0] grp_short;

	// Policy state as the predictor sees it after the last accepted beat.
	prof_t               profile_st;
	bit                  fine_mode;
	logic [31:0]         last_step_ms;
	logic [31:0]         last_prof_ms;
	logic [MA_WIDTH-1:0] cruise_active;

	// Results predicted at input acceptance, oldest first.
	out_t pending_results[$];
	out_t want_r;

	int send_idle_pct = 19;
	int recv_idle_pct = 45;
	logic [31:0] tick_ms = '0;

	int cycle_count  = 0;
	int fail_count   = 0;
	int report_count = 0;
	int n_checked    = 0;
	int n_service    = 0;
	int n_move       = 0;
	int n_writes     = 0;
	int n_applied    = 0;
	int n_switched   = 0;

	stepper_current_profile_policy u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A hard stop so that a hung handshake cannot run forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_results.size());
			$display("FAIL stepper_current_profile_policy");
			$finish;
		end
	end

	// The receiver stalls at random, at a rate that the running phase sets.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	// Every result beat is compared, field by field, with the oldest
	// prediction. Outputs are sampled at the edge, before any update it makes.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (report_count < MAX_REPORTS) begin
					$display("Result beat with nothing expected at cycle %0d", cycle_count);
					report_count++;
				end
			end else begin
				want_r = pending_results.pop_front();
				n_checked++;
				if (out_data.profile_now !== want_r.profile_now
						|| out_data.run_current_ma !== want_r.run_current_ma
						|| out_data.hold_percent !== want_r.hold_percent
						|| out_data.fine_steps !== want_r.fine_steps
						|| out_data.profile_applied !== want_r.profile_applied
						|| out_data.steps_switched !== want_r.steps_switched
						|| out_data.move_class !== want_r.move_class) begin
					fail_count++;
					if (report_count < MAX_REPORTS) begin
						$display("Mismatch on result %0d at cycle %0d (expected/actual):",
							n_checked, cycle_count);
						$display("  profile %0d/%0d current %0d/%0d hold %0d/%0d fine %0b/%0b",
							want_r.profile_now, out_data.profile_now,
							want_r.run_current_ma, out_data.run_current_ma,
							want_r.hold_percent, out_data.hold_percent,
							want_r.fine_steps, out_data.fine_steps);
						$display("  applied %0b/%0b switched %0b/%0b class %0d/%0d",
							want_r.profile_applied, out_data.profile_applied,
							want_r.steps_switched, out_data.steps_switched,
							want_r.move_class, out_data.move_class);
						report_count++;
					end
				end
			end
		end
	end

	// Register and state values that the block holds right after reset.
	task automatic reset_policy_copy();
		cfg_ready     = 1'b1;
		cfg_fast      = '0;
		grp_diag      = '0;
		grp_line      = '0;
		grp_short     = '0;
		profile_st    = PROF_CRUISE;
		fine_mode     = 1'b1;
		last_step_ms  = '0;
		last_prof_ms  = '0;
		cruise_active = '0;
	endtask

	// Advances the policy copy by one accepted beat and returns the result
	// that the block must report for it.
	function automatic out_t predict_policy_result(input in_t b);
		out_t                r;
		longint              va, vb, v, dx, dy, hi, lo;
		logic [MA_WIDTH-1:0] grp;
		logic [31:0]         since_step, since_prof;
		bit                  wants, prec, want_fine, applied, switched;
		prof_t               next_prof;
		cls_t                cls;

		applied  = 1'b0;
		switched = 1'b0;
		cls      = CLS_NONE;

		if (b.operation == OP_SERVICE) begin
			// With the driver link down a service beat leaves everything alone.
			if (cfg_ready) begin
				va = $signed(b.speed_a);
				vb = $signed(b.speed_b);
				if (va < 0) va = -va;
				if (vb < 0) vb = -vb;
				v = (va > vb) ? va : vb;
				wants = b.wants_move;
				prec  = b.precision_mode;
				want_fine = prec || !wants;

				// Microstep changes only near standstill or at idle, and only
				// once the dwell since the last change has passed (mod 2^32).
				since_step = b.now_ms - last_step_ms;
				if (want_fine != fine_mode && since_step >= STEP_DWELL_MS
						&& (!wants || v <= SPD_SAFE)) begin
					fine_mode    = want_fine;
					last_step_ms = b.now_ms;
					switched     = 1'b1;
					n_switched++;
				end

				next_prof = profile_st;
				if (!wants) begin
					next_prof = PROF_HOLD;
				end else begin
					case (profile_st)
						PROF_FAST: begin
							if (v <= SPD_FAST_DOWN) next_prof = PROF_CRUISE;
						end
						PROF_CRUISE: begin
							if (v >= SPD_FAST_UP) next_prof = PROF_FAST;
							else if (v <= SPD_CRUISE_DOWN && !prec) next_prof = PROF_HOLD;
						end
						default: begin
							if (v >= SPD_HOLD_UP || prec) next_prof = PROF_CRUISE;
						end
					endcase
				end

				since_prof = b.now_ms - last_prof_ms;
				if (next_prof != profile_st && since_prof >= PROFILE_DWELL_MS) begin
					profile_st   = next_prof;
					last_prof_ms = b.now_ms;
					applied      = 1'b1;
				end
			end
		end else if (grp_diag != 0 || grp_line != 0 || grp_short != 0) begin
			// A move beat is classified only when some group current is set.
			dx = longint'($signed(b.end_x)) - longint'($signed(b.start_x));
			dy = longint'($signed(b.end_y)) - longint'($signed(b.start_y));
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			hi = (dx > dy) ? dx : dy;
			lo = (dx < dy) ? dx : dy;
			if (hi <= SHORT_STEPS) begin
				cls = CLS_SHORT;
				grp = grp_short;
			end else if (lo > 0 && 10 * lo >= 3 * hi) begin
				cls = CLS_DIAG;
				grp = grp_diag;
			end else begin
				cls = CLS_LINE;
				grp = grp_line;
			end
			if (grp == 0) grp = cruise_active;
			if (grp != cruise_active) begin
				cruise_active = grp;
				if (profile_st == PROF_CRUISE) begin
					last_prof_ms = b.now_ms;
					applied      = 1'b1;
				end
			end
		end

		if (applied) n_applied++;

		r.profile_now = profile_st;
		case (profile_st)
			PROF_HOLD: r.run_current_ma = MA_WIDTH'(MA_HOLD);
			PROF_FAST: r.run_current_ma = (cfg_fast != 0) ? cfg_fast : MA_WIDTH'(MA_FAST_DEF);
			default:   r.run_current_ma = (cruise_active != 0) ? cruise_active
						: MA_WIDTH'(MA_CRUISE_DEF);
		endcase
		r.hold_percent    = (profile_st == PROF_HOLD) ? 6'(PCT_IDLE) : 6'(PCT_MOVE);
		r.fine_steps      = fine_mode;
		r.profile_applied = applied;
		r.steps_switched  = switched;
		r.move_class      = cls;
		return r;
	endfunction

	// A beat with every field random; callers overwrite what they care about.
	function automatic in_t make_noise();
		in_t b;
		b.operation      = 1'($urandom);
		b.now_ms         = $urandom;
		b.speed_a        = SPEED_WIDTH'($urandom);
		b.speed_b        = SPEED_WIDTH'($urandom);
		b.wants_move     = 1'($urandom);
		b.precision_mode = 1'($urandom);
		b.start_x        = COORD_WIDTH'($urandom);
		b.start_y        = COORD_WIDTH'($urandom);
		b.end_x          = COORD_WIDTH'($urandom);
		b.end_y          = COORD_WIDTH'($urandom);
		return b;
	endfunction

	function automatic in_t make_service(input logic [31:0] at_ms, input int sa, input int sb,
			input bit wants, input bit prec);
		in_t b;
		b = make_noise();
		b.operation      = OP_SERVICE;
		b.now_ms         = at_ms;
		b.speed_a        = SPEED_WIDTH'(sa);
		b.speed_b        = SPEED_WIDTH'(sb);
		b.wants_move     = wants;
		b.precision_mode = prec;
		return b;
	endfunction

	function automatic in_t make_move(input logic [31:0] at_ms, input int sx, input int sy,
			input int ex, input int ey);
		in_t b;
		b = make_noise();
		b.operation = OP_MOVE;
		b.now_ms    = at_ms;
		b.start_x   = COORD_WIDTH'(sx);
		b.start_y   = COORD_WIDTH'(sy);
		b.end_x     = COORD_WIDTH'(ex);
		b.end_y     = COORD_WIDTH'(ey);
		return b;
	endfunction

	// Speed magnitudes cluster around the profile and standstill thresholds
	// so that the hysteresis is exercised; some are fully random.
	function automatic int pick_speed();
		int m;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				case ($urandom_range(0, 5))
					0:       m = 0;
					1:       m = SPD_SAFE;
					2:       m = SPD_CRUISE_DOWN;
					3:       m = SPD_HOLD_UP;
					4:       m = SPD_FAST_DOWN;
					default: m = SPD_FAST_UP;
				endcase
				m = m + int'($urandom_range(0, 6)) - 3;
				if (m < 0) m = 0;
			end
			4, 5, 6: m = $urandom_range(0, 6000);
			7:       m = $urandom_range(0, 320);
			default: return int'($urandom);
		endcase
		return ($urandom_range(0, 1) != 0) ? -m : m;
	endfunction

	// Current settings favor the extremes, including values past the
	// saturation point of the registers.
	function automatic logic [MA_WIDTH-1:0] pick_ma();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return MA_WIDTH'(MA_MAX);
			2:       return '1;
			3:       return MA_WIDTH'(1);
			default: return MA_WIDTH'($urandom_range(0, MA_MAX));
		endcase
	endfunction

	// Offers one beat, waits for its acceptance and records its prediction.
	// After acceptance the sender goes quiet for each following cycle with
	// the phase's idle rate, so that share of its cycles is idle.
	task automatic send_beat(input in_t beat);
		in_valid <= 1'b1;
		in_data  <= beat;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_policy_result(beat));
		if (beat.operation == OP_MOVE) n_move++;
		else n_service++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every predicted result has come back,
	// then lets the two pipeline stages settle.
	task automatic drain_results(input int max_wait);
		in_valid <= 1'b0;
		for (int n = 0; n < max_wait && pending_results.size() != 0; n++) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write, taken at the next edge. The enable is lowered on a
	// later step than any raise, so back-to-back writes stay clean.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [MA_WIDTH-1:0] value);
		logic [MA_WIDTH-1:0] sat;
		sat = (value > MA_MAX) ? MA_WIDTH'(MA_MAX) : value;
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_DRIVERS_READY: cfg_ready = value[0];
			REG_CRUISE_OVR: cruise_active = sat;
			REG_FAST_OVR:  cfg_fast  = sat;
			REG_DIAG_GRP:  grp_diag  = sat;
			REG_LINE_GRP:  grp_line  = sat;
			REG_SHORT_GRP: grp_short = sat;
			default: ;
		endcase
		n_writes++;
		@(posedge clk);
	endtask

	// Walks the profile through hold, cruise and fast and the microstep mode
	// both ways, hitting each speed threshold exactly, the dwell blocks and a
	// timestamp that wraps past zero. Registers are at their reset values.
	task automatic test_profile_sequence();
		send_beat(make_service(32'd0, 0, 0, 1'b0, 1'b0));     // Held off by the dwell.
		send_beat(make_service(32'd120, 0, 0, 1'b0, 1'b0));   // Idle drops to hold.
		send_beat(make_service(32'd300, 151, 0, 1'b1, 1'b0)); // Too fast to go coarse.
		send_beat(make_service(32'd301, -150, 0, 1'b1, 1'b0));
		send_beat(make_service(32'd500, 699, 0, 1'b1, 1'b0));
		send_beat(make_service(32'd620, 0, 700, 1'b1, 1'b0));
		send_beat(make_service(32'd700, 524287, -524288, 1'b1, 1'b0)); // Dwell blocks fast.
		send_beat(make_service(32'd760, 524287, -524288, 1'b1, 1'b0));
		send_beat(make_service(32'd900, 4201, 0, 1'b1, 1'b0));
		send_beat(make_service(32'd1100, 0, -4200, 1'b1, 1'b0));
		send_beat(make_service(32'd1300, 250, 0, 1'b1, 1'b1)); // Precision keeps cruise.
		send_beat(make_service(32'd1500, 250, 0, 1'b1, 1'b0));
		send_beat(make_service(32'd1700, 0, 0, 1'b1, 1'b1));
		send_beat(make_service(32'hFFFF_FF00, 5200, 0, 1'b1, 1'b0));
		send_beat(make_service(32'h0000_0010, 0, 0, 1'b0, 1'b0)); // Dwell across the wrap.
	endtask

	// With the driver link down, service beats must change nothing while a
	// move beat is still handled; no group current is set, so it is skipped.
	task automatic test_drivers_not_ready();
		drain_results(DRAIN_LIMIT);
		write_reg(REG_DRIVERS_READY, 11'h7FE);
		send_beat(make_service(32'd2000, 6000, 0, 1'b1, 1'b0));
		send_beat(make_move(32'd2100, 0, 0, 5000, 0));
		drain_results(DRAIN_LIMIT);
		write_reg(REG_DRIVERS_READY, 11'h001);
	endtask

	// Class boundaries: the short limit, the exact diagonal ratio, a zero
	// minor axis at full coordinate span, fallback to the active cruise
	// current, a repeated current, and a new current outside cruise.
	task automatic test_move_classes();
		drain_results(DRAIN_LIMIT);
		write_reg(REG_FAST_OVR, 11'd1300);
		write_reg(REG_CRUISE_OVR, 11'd900);
		write_reg(REG_DIAG_GRP, 11'd600);
		write_reg(REG_LINE_GRP, 11'd0);
		write_reg(REG_SHORT_GRP, 11'h7FF);
		send_beat(make_service(32'd400, 800, 0, 1'b1, 1'b0));
		send_beat(make_move(32'd500, 0, 0, 160, -5));
		send_beat(make_move(32'd600, 100, 100, 400, 190));
		send_beat(make_move(32'd700, 0, 0, -300, 89));
		send_beat(make_move(32'd800, -8388608, 0, 8388607, 0));
		send_beat(make_move(32'd900, 0, 0, 161, -161));
		send_beat(make_service(32'd1000, 6000, 0, 1'b1, 1'b0));
		send_beat(make_move(32'd1100, 5, 5, 5, 5));
	endtask

	// Phases of random traffic, each with its own register settings and
	// idle pattern. Most beats follow a plausible timeline with advancing
	// timestamps; a few are pure noise.
	task automatic test_random_traffic();
		in_t         beat;
		int          roll, hi, lo, dx, dy, swap;
		logic [31:0] step;

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_results(DRAIN_LIMIT);
			// The first phase clears every current, the second drives them
			// past saturation, and the link goes down in one phase.
			write_reg(REG_DRIVERS_READY, {10'($urandom), 1'(phase != 4)});
			write_reg(REG_CRUISE_OVR, (phase == 0) ? '0 : (phase == 1) ? '1 : pick_ma());
			write_reg(REG_FAST_OVR, (phase == 0) ? '0 : (phase == 1) ? '1 : pick_ma());
			write_reg(REG_DIAG_GRP, (phase == 0) ? '0 : (phase == 1) ? '1 : pick_ma());
			write_reg(REG_LINE_GRP, (phase == 0) ? '0 : (phase == 1) ? '1 : pick_ma());
			write_reg(REG_SHORT_GRP, (phase == 0) ? '0 : (phase == 1) ? '1 : pick_ma());

			if (phase < 3) begin
				send_idle_pct = 19;
				recv_idle_pct = 45;
			end else if (phase < 6) begin
				send_idle_pct = 45;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// Now and then the sender holds back until the block is empty.
				if (k == ITEMS_PER_PHASE / 2 && phase % 3 == 1) drain_results(DRAIN_LIMIT);

				case ($urandom_range(0, 19))
					0:             step = '0;
					1:             step = $urandom;
					2, 3, 4, 5:    step = $urandom_range(100, 320);
					default:       step = $urandom_range(1, 130);
				endcase
				tick_ms = tick_ms + step;

				beat = make_noise();
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					// Fully random beat, left as made.
				end else if (roll < 32) begin
					beat.operation = OP_MOVE;
					beat.now_ms    = tick_ms;
					case ($urandom_range(0, 4))
						0: begin
							hi = $urandom_range(0, SHORT_STEPS + 3);
							lo = $urandom_range(0, hi);
						end
						1: begin
							// Right at the diagonal ratio boundary.
							hi = $urandom_range(SHORT_STEPS - 3, 5000);
							lo = (3 * hi + 9) / 10 + int'($urandom_range(0, 2)) - 1;
						end
						2: begin
							hi = $urandom_range(SHORT_STEPS + 1, 3000000);
							lo = $urandom_range((3 * hi + 9) / 10, hi);
						end
						default: begin
							hi = $urandom_range(SHORT_STEPS + 1, 3000000);
							lo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, (3 * hi) / 10);
						end
					endcase
					if (lo > hi) lo = hi;
					if (lo < 0) lo = 0;
					swap = $urandom_range(0, 1);
					dx = swap ? lo : hi;
					dy = swap ? hi : lo;
					if ($urandom_range(0, 1)) dx = -dx;
					if ($urandom_range(0, 1)) dy = -dy;
					if ($urandom_range(0, 3) != 0) begin
						beat.start_x = COORD_WIDTH'(int'($urandom_range(0, 4194304)) - 2097152);
						beat.start_y = COORD_WIDTH'(int'($urandom_range(0, 4194304)) - 2097152);
					end
					beat.end_x = COORD_WIDTH'(int'($signed(beat.start_x)) + dx);
					beat.end_y = COORD_WIDTH'(int'($signed(beat.start_y)) + dy);
				end else begin
					beat.operation      = OP_SERVICE;
					beat.now_ms         = tick_ms;
					beat.speed_a        = SPEED_WIDTH'(pick_speed());
					beat.speed_b        = SPEED_WIDTH'(pick_speed());
					beat.wants_move     = ($urandom_range(0, 99) < 85);
					beat.precision_mode = ($urandom_range(0, 99) < 25);
				end
				send_beat(beat);
			end
		end
	endtask

	// Reset is held low from the start and released on a clock edge, then the
	// tests run in turn and the run closes once every result is back.
	initial begin
		reset_policy_copy();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_profile_sequence();
		test_drivers_not_ready();
		test_move_classes();
		test_random_traffic();

		drain_results(DRAIN_LIMIT);
		if (pending_results.size() != 0) begin
			fail_count += pending_results.size();
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("Run covered %0d service and %0d move beats with %0d register writes.",
			n_service, n_move, n_writes);
		$display("Checked %0d results, of which %0d re-applied currents and %0d changed steps.",
			n_checked, n_applied, n_switched);
		if (fail_count == 0) begin
			$display("PASS stepper_current_profile_policy");
		end else begin
			$display("%0d failures", fail_count);
			$display("FAIL stepper_current_profile_policy");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/scpp_pkg.sv
sv/scpp_move_class.sv
sv/stepper_current_profile_policy.sv
sv/scpp_checker.sv
verif/testbench.sv
